// ===== rtl/jse_pkg.sv =====
// Shared types, constants and escape table for the JSON string escaper.
package jse_pkg;

  localparam int LEN_W      = 16;            // width of the running length
  localparam int IDX_W      = 16;            // width of byte_index
  localparam int SIZE_W     = 16;            // width of buffer_size
  localparam int MAX_BYTES  = 8;             // most bytes one request can produce
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int SEL_W      = $clog2(MAX_BYTES);
  localparam int PIECE_MAX  = 6;             // longest escape: backslash-u and 4 hex digits
  localparam int PLEN_W     = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-1:0] REG_BUFFER_SIZE = 3'd0;
  localparam logic [SIZE_W-1:0]  BUFFER_SIZE_RST = 16'hFFFF;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_CTRL_TOP  = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_string;
    logic       last_of_string;
    logic       no_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] byte_index;
    logic             out_last;
    logic             overflow;
  } out_rsp_t;

  // one classified request: bytes left-aligned, first byte in the top lane
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [CNT_W-1:0]       cnt;
    logic [IDX_W-1:0]       base;
    logic                   ovf;
  } desc_t;

  typedef struct packed {
    logic [8*PIECE_MAX-1:0] bytes;   // left-aligned
    logic [PLEN_W-1:0]      len;
  } piece_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    hex_digit = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  function automatic piece_t escape_piece(input logic [7:0] c);
    piece_t p;
    p.bytes = '0;
    p.len   = 3'd2;
    p.bytes[47:40] = CH_BACKSLASH;
    unique case (c)
      CH_QUOTE:     p.bytes[39:32] = CH_QUOTE;
      CH_BACKSLASH: p.bytes[39:32] = CH_BACKSLASH;
      CH_NL:        p.bytes[39:32] = 8'h6E;
      CH_CR:        p.bytes[39:32] = 8'h72;
      CH_TAB:       p.bytes[39:32] = 8'h74;
      CH_BS:        p.bytes[39:32] = 8'h62;
      CH_FF:        p.bytes[39:32] = 8'h66;
      default: begin
        if (c < CH_CTRL_TOP) begin
          p.bytes[39:0] = {8'h75, 8'h30, 8'h30, hex_digit(c[7:4]), hex_digit(c[3:0])};
          p.len         = 3'd6;
        end else begin
          p.bytes[47:40] = c;
          p.len          = 3'd1;
        end
      end
    endcase
    escape_piece = p;
  endfunction

endpackage

// ===== rtl/jse_front.sv =====
// Front end: classifies each request, checks fit, tracks length and overflow.
module jse_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [jse_pkg::SIZE_W-1:0] buffer_size,
  input  logic                    in_fire,
  input  jse_pkg::in_req_t        in_req,
  output logic                    push,
  output jse_pkg::desc_t          push_desc
);
  import jse_pkg::*;

  logic [LEN_W-1:0] written_length, written_length_next;
  logic             overflow_flag, overflow_flag_next;

  always_comb begin
    logic [LEN_W-1:0]       wl;
    logic                   ovf;
    logic [8*MAX_BYTES-1:0] acc;
    logic [CNT_W-1:0]       cnt;
    logic [LEN_W:0]         sum;
    piece_t                 quote_p;
    piece_t                 esc_p;

    wl  = written_length;
    ovf = overflow_flag;
    acc = '0;
    cnt = '0;
    sum = '0;
    quote_p.bytes = {CH_QUOTE, 40'd0};
    quote_p.len   = 3'd1;
    esc_p = escape_piece(in_req.data_byte);

    // opening quote
    if (in_req.first_of_string && !ovf) begin
      sum = {1'b0, wl} + (LEN_W+1)'(quote_p.len);
      if (sum >= (LEN_W+1)'(buffer_size)) begin
        ovf = 1'b1;
      end else begin
        acc = acc | ({quote_p.bytes, 16'd0} >> {cnt, 3'b000});
        cnt = cnt + CNT_W'(quote_p.len);
        wl  = sum[LEN_W-1:0];
      end
    end
    // the byte itself, escaped
    if (!in_req.no_char && !ovf) begin
      sum = {1'b0, wl} + (LEN_W+1)'(esc_p.len);
      if (sum >= (LEN_W+1)'(buffer_size)) begin
        ovf = 1'b1;
      end else begin
        acc = acc | ({esc_p.bytes, 16'd0} >> {cnt, 3'b000});
        cnt = cnt + CNT_W'(esc_p.len);
        wl  = sum[LEN_W-1:0];
      end
    end
    // closing quote
    if (in_req.last_of_string && !ovf) begin
      sum = {1'b0, wl} + (LEN_W+1)'(quote_p.len);
      if (sum >= (LEN_W+1)'(buffer_size)) begin
        ovf = 1'b1;
      end else begin
        acc = acc | ({quote_p.bytes, 16'd0} >> {cnt, 3'b000});
        cnt = cnt + CNT_W'(quote_p.len);
        wl  = sum[LEN_W-1:0];
      end
    end

    written_length_next = wl;
    overflow_flag_next  = ovf;
    push_desc.bytes     = acc;
    push_desc.cnt       = cnt;
    push_desc.base      = IDX_W'(written_length);
    push_desc.ovf       = ovf;
    push                = in_fire && (cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written_length <= '0;
      overflow_flag  <= 1'b0;
    end else if (in_fire) begin
      written_length <= written_length_next;
      overflow_flag  <= overflow_flag_next;
    end
  end

endmodule

// ===== rtl/jse_fifo.sv =====
// Short descriptor queue between front end and back end.
module jse_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jse_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output jse_pkg::desc_t head
);
  import jse_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  desc_t                mem [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       count;

  assign full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/jse_back.sv =====
// Back end: walks a descriptor one output byte per cycle while out_stall is low.
module jse_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  jse_pkg::desc_t   q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output jse_pkg::out_rsp_t out_rsp
);
  import jse_pkg::*;

  desc_t            cur;
  logic             busy;
  logic [SEL_W-1:0] sel;
  logic             at_end;
  logic             advance;

  assign at_end  = ({1'b0, sel} == (cur.cnt - 1'b1));
  assign advance = busy && !out_stall;
  assign pop     = !q_empty && (!busy || (advance && at_end));

  assign out_valid          = busy;
  assign out_rsp.out_byte   = cur.bytes[8*MAX_BYTES-1 - 8*sel -: 8];
  assign out_rsp.byte_index = cur.base + IDX_W'(sel);
  assign out_rsp.out_last   = at_end;
  assign out_rsp.overflow   = cur.ovf;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      sel  <= '0;
    end else if (advance) begin
      if (at_end) begin
        busy <= 1'b0;
        sel  <= '0;
      end else begin
        sel <= sel + 1'b1;
      end
    end
  end

  a_sel_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, sel} < cur.cnt))
    else $error("byte select past descriptor length");
  a_nonempty_desc: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.cnt != '0))
    else $error("empty descriptor in back end");
  a_sticky_ovf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_rsp.overflow) |=> (!out_valid || out_rsp.overflow))
    else $error("overflow flag dropped after being set");

endmodule

// ===== rtl/json_string_escaper_unit.sv =====
// Top level of the JSON string escaper: config register, front, queue, back.
// A request is queued, then loaded into the back end before its bytes are output.
// Throughput: one request per cycle in unless the queue is full; one output byte
//   per cycle out unless out_stall is high. A request of k bytes (k up to 8, 6 for
//   a control char) ties up the back end; the two-entry descriptor queue absorbs it.
// Reset (rst, synchronous): clears length, overflow flag, queue and back end;
//   buffer_size returns to 65535.
module json_string_escaper_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jse_pkg::in_req_t              in_req,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output jse_pkg::out_rsp_t             out_rsp,
  // APB config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jse_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import jse_pkg::*;

  logic [SIZE_W-1:0] buffer_size;
  logic              cfg_wr;
  logic              in_fire;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  desc_t             push_desc;
  desc_t             q_head;

  // APB: zero wait states; the register decodes on the word address only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[PADDR_W-1:2] == REG_BUFFER_SIZE[PADDR_W-1:2]);
  assign prdata = (paddr[PADDR_W-1:2] == REG_BUFFER_SIZE[PADDR_W-1:2])
                ? {16'd0, buffer_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RST;
    end else if (cfg_wr) begin
      buffer_size <= pwdata[SIZE_W-1:0];
    end
  end

  // stall only on a full queue; requests that produce no bytes never enter it
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  jse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .buffer_size(buffer_size),
    .in_fire    (in_fire),
    .in_req     (in_req),
    .push       (push),
    .push_desc  (push_desc)
  );

  jse_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  jse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

endmodule
